// ===== sv/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg: shared constants for the triangle unit normal block
// Default widths of the coordinates, of the normal fraction and of the result.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 14;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_W                = 16;

endpackage

// ===== sv/triangle_unit_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of a triangle in fixed point
// Exact cross product, sum of squares and a pipelined divide/square root.
// ----------------------------------------------------------------------------
// This block takes one triangle per beat and returns its unit face normal as
// three signed Q1.F components, each truncated toward zero, with a flag for a
// triangle whose cross product is zero (all components then read zero). It
// is fully pipelined: a new triangle may enter on every clock while the
// output beat is not held back. Most of the pipeline depth lies in the
// normalization, which spends one stage per quotient bit of the division
// and one stage per result bit of the square root. The whole pipeline
// advances whenever the output register is empty or its beat is taken, so
// back pressure holds every stage in place and nothing is lost.
// ----------------------------------------------------------------------------
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int S_TDATA_W       = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up, zero padded
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // normal_x, normal_y, normal_z from the lowest bit up
    output logic [47:0]          m_tdata,
    // degenerate
    output logic                 m_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int OW    = tun_pkg::OUT_W;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int NW    = PW + 1;
    localparam int MAG_W = PW;
    localparam int C2_W  = 2 * MAG_W;
    localparam int SW    = C2_W + 2;
    localparam int LL    = 3 * F + 2;
    localparam int EW    = (F + 2 > OW) ? F + 2 : OW;

    typedef struct packed {
        logic       valid;
        logic       deg;
        logic [2:0] sgn;
    } side_t;

    // The whole pipeline moves together when the output slot can accept.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: edge vectors u = b - a and v = c - a.
    logic              v1_reg;
    logic signed [DW-1:0] u_reg [0:2];
    logic signed [DW-1:0] w_reg [0:2];
    logic signed [DW-1:0] crd   [0:8];

    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_crd
            assign crd[k] = DW'($signed(s_tdata[k*CW +: CW]));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= crd[3+i] - crd[i];
                w_reg[i] <= crd[6+i] - crd[i];
            end
        end
    end

    // Stage 2: the six partial products of the cross product.
    logic              v2_reg;
    logic signed [PW-1:0] p_reg [0:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= PW'(u_reg[1]) * PW'(w_reg[2]);
            p_reg[1] <= PW'(w_reg[1]) * PW'(u_reg[2]);
            p_reg[2] <= PW'(u_reg[2]) * PW'(w_reg[0]);
            p_reg[3] <= PW'(w_reg[2]) * PW'(u_reg[0]);
            p_reg[4] <= PW'(u_reg[0]) * PW'(w_reg[1]);
            p_reg[5] <= PW'(w_reg[0]) * PW'(u_reg[1]);
        end
    end

    // Stage 3: cross components, their magnitudes, signs and the zero check.
    side_t               sd3_reg;
    logic [MAG_W-1:0]    mag3_reg [0:2];
    logic signed [NW-1:0] n       [0:2];
    logic [NW-1:0]       nabs     [0:2];

    generate
        for (k = 0; k < 3; k++) begin : g_cross
            assign n[k]    = NW'(p_reg[2*k]) - NW'(p_reg[2*k+1]);
            assign nabs[k] = n[k][NW-1] ? NW'(-n[k]) : NW'(n[k]);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd3_reg.valid <= 1'b0;
        end else if (en) begin
            sd3_reg.valid <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd3_reg.deg <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
            for (int i = 0; i < 3; i++) begin
                sd3_reg.sgn[i] <= n[i][NW-1];
                mag3_reg[i]    <= nabs[i][MAG_W-1:0];
            end
        end
    end

    // Stage 4: squares of the magnitudes.
    side_t            sd4_reg;
    logic [C2_W-1:0]  c2_4_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd4_reg.valid <= 1'b0;
        end else if (en) begin
            sd4_reg.valid <= sd3_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd4_reg.deg <= sd3_reg.deg;
            sd4_reg.sgn <= sd3_reg.sgn;
            for (int i = 0; i < 3; i++) begin
                c2_4_reg[i] <= C2_W'(mag3_reg[i]) * C2_W'(mag3_reg[i]);
            end
        end
    end

    // Stage 5: sum of squares S.
    side_t           sd5_reg;
    logic [C2_W-1:0] c2_5_reg [0:2];
    logic [SW-1:0]   s5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd5_reg.valid <= 1'b0;
        end else if (en) begin
            sd5_reg.valid <= sd4_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd5_reg.deg <= sd4_reg.deg;
            sd5_reg.sgn <= sd4_reg.sgn;
            s5_reg      <= SW'(c2_4_reg[0]) + SW'(c2_4_reg[1]) + SW'(c2_4_reg[2]);
            for (int i = 0; i < 3; i++) begin
                c2_5_reg[i] <= c2_4_reg[i];
            end
        end
    end

    // Normalization lanes, one per component. A zero S runs through them
    // harmlessly; the degenerate flag masks the result at the output.
    logic [F:0] mag_l [0:2];

    generate
        for (k = 0; k < 3; k++) begin : g_lane
            tun_lane #(
                .C2_W (C2_W),
                .F    (F)
            ) u_lane (
                .aclk  (aclk),
                .en    (en),
                .c2    (c2_5_reg[k]),
                .s_sum (s5_reg),
                .mag   (mag_l[k])
            );
        end
    endgenerate

    // Side information rides along with the lanes. Only the valid bits are
    // cleared by reset.
    side_t sd_reg [0:LL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LL; i++) begin
                sd_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            sd_reg[0].valid <= sd5_reg.valid;
            for (int i = 1; i < LL; i++) begin
                sd_reg[i].valid <= sd_reg[i-1].valid;
            end
        end
        if (en) begin
            sd_reg[0].deg <= sd5_reg.deg;
            sd_reg[0].sgn <= sd5_reg.sgn;
            for (int i = 1; i < LL; i++) begin
                sd_reg[i].deg <= sd_reg[i-1].deg;
                sd_reg[i].sgn <= sd_reg[i-1].sgn;
            end
        end
    end

    // Output register: apply the signs, wrap to the result width.
    logic          m_tvalid_reg;
    logic [47:0]   m_tdata_reg;
    logic          m_tuser_reg;
    logic [EW-1:0] sgn_val [0:2];

    generate
        for (k = 0; k < 3; k++) begin : g_out
            assign sgn_val[k] = sd_reg[LL-1].deg ? '0 :
                                sd_reg[LL-1].sgn[k] ? EW'(-EW'(mag_l[k])) : EW'(mag_l[k]);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= sd_reg[LL-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sgn_val[2][OW-1:0], sgn_val[1][OW-1:0], sgn_val[0][OW-1:0]};
            m_tuser_reg <= sd_reg[LL-1].deg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/tun_lane.sv =====
// ----------------------------------------------------------------------------
// tun_lane: pipelined normalization of one normal component
// Restoring division c2 * 2^(2F) / S, one quotient bit per stage, then an
// integer square root of the quotient, one result bit per stage.
// ----------------------------------------------------------------------------
module tun_lane #(
    parameter int C2_W = 2 * 2 * (tun_pkg::COORD_WIDTH_DEF + 1),
    parameter int F    = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [C2_W-1:0]   c2,
    input  logic [C2_W+1:0]   s_sum,
    output logic [F:0]        mag
);

    localparam int SW  = C2_W + 2;
    localparam int RW  = SW + 1;
    localparam int QW  = 2 * F + 1;
    localparam int SQW = 2 * F + 2;

    logic [RW-1:0] r_reg [0:QW-1];
    logic [QW-1:0] q_reg [0:QW-1];
    logic [SW-1:0] s_reg [0:QW-1];

    logic [QW-1:0]  qv_reg [0:F];
    logic [F:0]     m_reg  [0:F];
    logic [SQW-1:0] sq_reg [0:F];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_div
            logic [RW-1:0] r_in;
            logic [QW-1:0] q_in;
            logic [SW-1:0] s_in;
            logic          ge;
            logic [RW-1:0] rd;
            if (i == 0) begin : g_first
                assign r_in = RW'(c2);
                assign q_in = '0;
                assign s_in = s_sum;
            end else begin : g_next
                assign r_in = r_reg[i-1];
                assign q_in = q_reg[i-1];
                assign s_in = s_reg[i-1];
            end
            assign ge = r_in >= RW'(s_in);
            assign rd = ge ? r_in - RW'(s_in) : r_in;
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i] <= {rd[RW-2:0], 1'b0};
                    q_reg[i] <= {q_in[QW-2:0], ge};
                    s_reg[i] <= s_in;
                end
            end
        end

        for (i = 0; i <= F; i++) begin : g_sqrt
            localparam int B = F - i;
            logic [QW-1:0]  qv_in;
            logic [F:0]     m_in;
            logic [SQW-1:0] sq_in;
            logic [SQW-1:0] cand;
            logic           take;
            if (i == 0) begin : g_first
                assign qv_in = q_reg[QW-1];
                assign m_in  = '0;
                assign sq_in = '0;
            end else begin : g_next
                assign qv_in = qv_reg[i-1];
                assign m_in  = m_reg[i-1];
                assign sq_in = sq_reg[i-1];
            end
            // (m + 2^b)^2 = m^2 + m * 2^(b+1) + 2^(2b)
            assign cand = sq_in + (SQW'(m_in) << (B + 1)) + (SQW'(1) << (2 * B));
            assign take = cand <= SQW'(qv_in);
            always_ff @(posedge aclk) begin
                if (en) begin
                    qv_reg[i] <= qv_in;
                    m_reg[i]  <= take ? (m_in | ((F+1)'(1) << B)) : m_in;
                    sq_reg[i] <= take ? cand : sq_in;
                end
            end
        end
    endgenerate

    assign mag = m_reg[F];

endmodule
